// ===== rtl/mvpq_pkg.sv =====
// Shared types, codes and defaults for the mesh vertex predictive quantizer.
package mvpq_pkg;

  localparam int MAX_VERTICES_DEF = 4096;
  localparam int COORD_BITS_DEF   = 32;
  localparam int SLOT_BITS        = 12;
  localparam int STEP_BITS        = 31;
  localparam logic [STEP_BITS-1:0] STEP_RESET = 31'd65536;

  typedef enum logic [1:0] {
    ACT_BOUNDARY = 2'd0,
    ACT_MIDPOINT = 2'd1,
    ACT_PARALLEL = 2'd2,
    ACT_RESERVED = 2'd3
  } action_t;

  typedef struct packed {
    logic        [1:0]           action;
    logic signed [31:0]          real_x;
    logic signed [31:0]          real_y;
    logic signed [31:0]          real_z;
    logic        [SLOT_BITS-1:0] dest_slot;
    logic        [SLOT_BITS-1:0] nbr_a;
    logic        [SLOT_BITS-1:0] nbr_b;
    logic        [SLOT_BITS-1:0] nbr_c;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] qdelta_x;
    logic signed [31:0] qdelta_y;
    logic signed [31:0] qdelta_z;
    logic signed [31:0] recon_x;
    logic signed [31:0] recon_y;
    logic signed [31:0] recon_z;
  } out_item_t;

  typedef struct packed {
    logic    start;
    action_t action;
  } lane_cmd_t;

endpackage

// ===== rtl/mvpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mvpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mvpq_lane.sv =====
// One axis lane: prediction, restoring division, saturation and reconstruction.
module mvpq_lane #(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mvpq_pkg::lane_cmd_t           cmd,
  input  logic signed [31:0]            real_in,
  input  logic signed [COORD_BITS-1:0]  va,
  input  logic signed [COORD_BITS-1:0]  vb,
  input  logic signed [COORD_BITS-1:0]  vc,
  input  logic [mvpq_pkg::STEP_BITS-1:0] step,
  output logic                          done,
  output logic signed [31:0]            q,
  output logic signed [COORD_BITS-1:0]  rec
);
  import mvpq_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PW = CB + 2;
  localparam int DW = (CB + 3 > 33) ? CB + 3 : 33;
  localparam int CW = $clog2(DW + 1);
  localparam logic signed [63:0] HI = (64'sd1 <<< (CB - 1)) - 64'sd1;
  localparam logic signed [63:0] LO = -HI - 64'sd1;

  typedef enum logic [2:0] {
    L_IDLE, L_PRED, L_DIV, L_SAT, L_MUL, L_ADD
  } lstate_t;

  lstate_t                 state;
  action_t                 act;
  logic signed [31:0]      real_r;
  logic signed [CB-1:0]    ra, rb, rc;
  logic [STEP_BITS-1:0]    step_r;
  logic signed [PW-1:0]    pred;
  logic                    neg;
  logic [DW-1:0]           num;
  logic [STEP_BITS-1:0]    rem;
  logic [CW-1:0]           cnt;
  logic signed [63:0]      prod;

  logic signed [CB:0]      s;
  logic signed [PW-1:0]    pred_next;
  logic signed [DW-1:0]    diff;
  logic [STEP_BITS:0]      rem_sh;
  logic                    qbit;
  logic signed [63:0]      real64;
  logic signed [63:0]      sum;

  always_comb begin
    s = {ra[CB-1], ra} + {rb[CB-1], rb};
    if (act == ACT_MIDPOINT) begin
      pred_next = {{2{s[CB]}}, s[CB:1]};
    end else begin
      pred_next = {s[CB], s} - {{2{rc[CB-1]}}, rc};
    end
    diff = {{(DW-32){real_r[31]}}, real_r} - {{(DW-PW){pred_next[PW-1]}}, pred_next};
    rem_sh = {rem, num[DW-1]};
    qbit = (rem_sh >= {1'b0, step_r});
    real64 = {{32{real_in[31]}}, real_in};
    sum = {{(64-PW){pred[PW-1]}}, pred} + prod;
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= L_IDLE;
    end else begin
      unique case (state)
        L_IDLE: begin
          if (cmd.start) begin
            act    <= cmd.action;
            real_r <= real_in;
            ra     <= va;
            rb     <= vb;
            rc     <= vc;
            step_r <= step;
            if (cmd.action == ACT_MIDPOINT || cmd.action == ACT_PARALLEL) begin
              state <= L_PRED;
            end else begin
              q <= '0;
              if (cmd.action == ACT_BOUNDARY) begin
                if (real64 > HI) begin
                  rec <= HI[CB-1:0];
                end else if (real64 < LO) begin
                  rec <= LO[CB-1:0];
                end else begin
                  rec <= real64[CB-1:0];
                end
              end else begin
                rec <= '0;
              end
              done <= 1'b1;
            end
          end
        end
        L_PRED: begin
          pred  <= pred_next;
          neg   <= diff[DW-1];
          num   <= diff[DW-1] ? DW'(-diff) : DW'(diff);
          rem   <= '0;
          cnt   <= CW'(DW);
          state <= L_DIV;
        end
        L_DIV: begin
          rem <= qbit ? STEP_BITS'(rem_sh - {1'b0, step_r}) : rem_sh[STEP_BITS-1:0];
          num <= {num[DW-2:0], qbit};
          cnt <= cnt - 1'b1;
          if (cnt == CW'(1)) begin
            state <= L_SAT;
          end
        end
        L_SAT: begin
          if (neg) begin
            q <= (num > {{(DW-32){1'b0}}, 32'h8000_0000}) ? 32'sh8000_0000
                                                            : -$signed(num[31:0]);
          end else begin
            q <= (num > {{(DW-32){1'b0}}, 32'h7FFF_FFFF}) ? 32'sh7FFF_FFFF
                                                            : $signed(num[31:0]);
          end
          state <= L_MUL;
        end
        L_MUL: begin
          prod  <= q * $signed({1'b0, step_r});
          state <= L_ADD;
        end
        L_ADD: begin
          if (sum > HI) begin
            rec <= HI[CB-1:0];
          end else if (sum < LO) begin
            rec <= LO[CB-1:0];
          end else begin
            rec <= sum[CB-1:0];
          end
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/mesh_vertex_predictive_quantizer.sv =====
// Top level: vertex store, neighbor fetch, three axis lanes and result merge.
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_ready   in_data  (in_item_t)
//   out      out  out_valid/out_ready out_data (out_item_t)
//   cfg      in   cfg_we              cfg_wdata (step_size)
//
// Predictive modes: three neighbor reads, then in each lane prediction, a
// one-bit-per-cycle restoring division of a DW-bit dividend, DW =
// max(33, COORD_BITS+3), saturation, multiply and add; boundary and unused
// actions skip them. The next input waits until the result is registered.
// The three neighbor reads share one RAM read port.
// Synchronous reset clears control only; the vertex store is not cleared.
// A new item is taken while the previous result waits; merge holds on out stall.
module mesh_vertex_predictive_quantizer #(
  parameter int MAX_VERTICES = mvpq_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = mvpq_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mvpq_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mvpq_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [mvpq_pkg::STEP_BITS-1:0] cfg_wdata
);
  import mvpq_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int RK = SLOT_BITS + AW;
  localparam logic [SLOT_BITS:0] RM = (SLOT_BITS+1)'(((64'd1 << RK) +
                                      64'(MAX_VERTICES) - 64'd1) / 64'(MAX_VERTICES));
  localparam logic signed [63:0] HI32 = 64'sd2147483647;
  localparam logic signed [63:0] LO32 = -64'sd2147483648;

  typedef enum logic [2:0] {
    S_IDLE, S_RA, S_RB, S_RC, S_RL, S_GO, S_RUN, S_FIN
  } state_t;

  state_t               state;
  in_item_t             item;
  logic [STEP_BITS-1:0] step_size;
  logic [STEP_BITS-1:0] step_eff;
  logic [3*CB-1:0]      va, vb, vc;
  logic [AW-1:0]        raddr;
  logic [3*CB-1:0]      rdata;
  logic                 we;
  lane_cmd_t            cmd;
  logic [2:0]           ldone;
  logic [2:0]           lfin;
  logic signed [31:0]   lq   [3];
  logic signed [CB-1:0] lrec [3];
  logic signed [31:0]   lreal [3];
  logic signed [31:0]   rec32 [3];

  function automatic logic [AW-1:0] slot_idx(input logic [SLOT_BITS-1:0] s);
    logic [2*SLOT_BITS:0] prod;
    logic [SLOT_BITS-1:0] quo;
    logic [SLOT_BITS-1:0] rem;
    if (MAX_VERTICES >= (1 << SLOT_BITS)) begin
      return AW'(s);
    end
    prod = (2*SLOT_BITS+1)'(s) * (2*SLOT_BITS+1)'(RM);
    quo  = SLOT_BITS'(prod >> RK);
    rem  = s - SLOT_BITS'(quo * SLOT_BITS'(MAX_VERTICES));
    return AW'(rem);
  endfunction

  always_comb begin
    unique case (state)
      S_RA:    raddr = slot_idx(item.nbr_a);
      S_RB:    raddr = slot_idx(item.nbr_b);
      default: raddr = slot_idx(item.nbr_c);
    endcase
  end

  assign step_eff   = (step_size == '0) ? STEP_BITS'(1) : step_size;
  assign in_ready   = (state == S_IDLE);
  assign cmd.start  = (state == S_GO);
  assign cmd.action = action_t'(item.action);
  assign we         = (state == S_FIN) && (!out_valid || out_ready) &&
                      (action_t'(item.action) != ACT_RESERVED);
  assign lreal[0]   = item.real_x;
  assign lreal[1]   = item.real_y;
  assign lreal[2]   = item.real_z;

  mvpq_ram #(.WIDTH(3*CB), .DEPTH(MAX_VERTICES)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (slot_idx(item.dest_slot)),
    .wdata ({lrec[2], lrec[1], lrec[0]}),
    .raddr (raddr),
    .rdata (rdata)
  );

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [63:0] r64;
    mvpq_lane #(.COORD_BITS(CB)) u_lane (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .real_in (lreal[i]),
      .va      (va[i*CB +: CB]),
      .vb      (vb[i*CB +: CB]),
      .vc      (vc[i*CB +: CB]),
      .step    (step_eff),
      .done    (ldone[i]),
      .q       (lq[i]),
      .rec     (lrec[i])
    );
    assign r64 = {{(64-CB){lrec[i][CB-1]}}, lrec[i]};
    assign rec32[i] = (r64 > HI32) ? 32'sh7FFF_FFFF :
                      (r64 < LO32) ? 32'sh8000_0000 : r64[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step_size <= STEP_RESET;
      out_valid <= 1'b0;
      lfin      <= '0;
    end else begin
      if (cfg_we) begin
        step_size <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            if (action_t'(in_data.action) == ACT_MIDPOINT ||
                action_t'(in_data.action) == ACT_PARALLEL) begin
              state <= S_RA;
            end else begin
              state <= S_GO;
            end
          end
        end
        S_RA: state <= S_RB;
        S_RB: begin
          va    <= rdata;
          state <= S_RC;
        end
        S_RC: begin
          vb    <= rdata;
          state <= S_RL;
        end
        S_RL: begin
          vc    <= rdata;
          state <= S_GO;
        end
        S_GO: begin
          lfin  <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          lfin <= lfin | ldone;
          if ((lfin | ldone) == 3'b111) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_data.qdelta_x <= lq[0];
            out_data.qdelta_y <= lq[1];
            out_data.qdelta_z <= lq[2];
            out_data.recon_x  <= rec32[0];
            out_data.recon_y  <= rec32[1];
            out_data.recon_z  <= rec32[2];
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
